// ----- hw/rtl/stff_pkg.sv -----
// stff_pkg: constants, codes and controller/datapath interface types for the
// first-free slot table. No dependencies.

package stff_pkg;

   localparam int CAPACITY = 64;
   localparam int CHUNK    = 8;
   localparam int VALUE_W  = 32;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CLR_W    = (CHUNK > 1) ? $clog2(CHUNK) : 1;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_FIND   = 2'd1,
      OP_GET    = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_NOT_FOUND = 2'd2,
      ST_FULL      = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_CLEAR,
      S_SCAN,
      S_FINISH
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       load_req;
      logic       clr_start;
      logic       clr_step;
      logic       grow_commit;
      logic       scan_start;
      logic       scan_step;
      logic       get_read;
      logic       commit_add;
      logic       commit_remove;
      logic       rsp_load;
      status_type rsp_status;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      op_type op;
      logic   val_zero;
      logic   get_in_range;
      logic   need_grow;
      logic   grow_fits;
      logic   clr_last;
      logic   scan_hit;
      logic   scan_end;
      logic   out_free;
   } stat_type;

endpackage

// ----- hw/rtl/slot_table_first_free_top.sv -----
// Slot table with first-free allocation of 64 slots of 32-bit nonzero values, one item
// at a time. Get and every invalid request go from decode straight to the result stage.
// Find, remove and add scan the usable slots through the store's single read port, one
// slot per cycle. An add that finds the table full first zeroes a new chunk of 8 slots
// if one fits. The result waits in an output register, and the next item is accepted
// while it is held. Depends on stff_pkg, stff_ctrl and stff_datapath.

module slot_table_first_free_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_op,
   input  logic [stff_pkg::VALUE_W-1:0]  req_value,
   input  logic [stff_pkg::ADDR_W-1:0]   req_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [stff_pkg::ADDR_W-1:0]   rsp_slot_index,
   output logic [stff_pkg::VALUE_W-1:0]  rsp_slot_value
);
   import stff_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   stff_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   stff_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .req_op         (req_op),
      .req_value      (req_value),
      .req_index      (req_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index),
      .rsp_slot_value (rsp_slot_value)
   );

endmodule

// ----- hw/rtl/stff_datapath.sv -----
// stff_datapath: slot store, request and count registers, scan pipeline and
// result register of the slot table. Depends on stff_pkg.

module stff_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  stff_pkg::cmd_type             cmd,
   output stff_pkg::stat_type            stat,
   input  logic [1:0]                    req_op,
   input  logic [stff_pkg::VALUE_W-1:0]  req_value,
   input  logic [stff_pkg::ADDR_W-1:0]   req_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_status,
   output logic [stff_pkg::ADDR_W-1:0]   rsp_slot_index,
   output logic [stff_pkg::VALUE_W-1:0]  rsp_slot_value
);
   import stff_pkg::*;

   logic [VALUE_W-1:0] mem [CAPACITY];

   op_type             op_ff;
   logic [VALUE_W-1:0] value_ff;
   logic [ADDR_W-1:0]  index_ff;

   logic [CNT_W-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]   usable_ff, usable_in;
   logic [CNT_W-1:0]   addr_ff, addr_in;
   logic [CLR_W-1:0]   clr_cnt_ff, clr_cnt_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic [VALUE_W-1:0] rd_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff;
   logic [ADDR_W-1:0]  rsp_index_ff;
   logic [VALUE_W-1:0] rsp_value_ff;

   logic [VALUE_W-1:0] target;
   logic               issue;
   logic [CNT_W-1:0]   used_dec;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [VALUE_W-1:0] mem_wdata;
   logic [ADDR_W-1:0]  mem_raddr;

   // add looks for an empty slot, find and remove for the value
   assign target   = (op_ff == OP_ADD) ? '0 : value_ff;
   assign issue    = addr_ff < usable_ff;
   assign used_dec = (used_ff != '0) ? used_ff - CNT_W'(1) : '0;

   always_comb begin
      stat.op           = op_ff;
      stat.val_zero     = (value_ff == '0);
      stat.get_in_range = CNT_W'(index_ff) < usable_ff;
      stat.need_grow    = used_ff >= usable_ff;
      stat.grow_fits    = ({1'b0, usable_ff} + (CNT_W + 1)'(CHUNK))
                          <= (CNT_W + 1)'(CAPACITY);
      stat.clr_last     = (clr_cnt_ff == CLR_W'(CHUNK - 1));
      stat.scan_hit     = rd_valid_ff && (rd_ff == target);
      stat.scan_end     = !rd_valid_ff && !issue;
      stat.out_free     = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = rd_addr_ff;
      mem_wdata = '0;
      if (cmd.clr_step) begin
         mem_we    = 1'b1;
         mem_waddr = usable_ff[ADDR_W-1:0] + ADDR_W'(clr_cnt_ff);
      end else if (cmd.commit_add) begin
         mem_we    = 1'b1;
         mem_wdata = value_ff;
      end else if (cmd.commit_remove) begin
         mem_we    = 1'b1;
      end
      mem_raddr = cmd.get_read ? index_ff : addr_ff[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.scan_step || cmd.get_read) begin
         rd_ff <= mem[mem_raddr];
      end
   end

   always_comb begin
      used_in     = used_ff;
      usable_in   = usable_ff;
      addr_in     = addr_ff;
      clr_cnt_in  = clr_cnt_ff;
      rd_valid_in = rd_valid_ff;
      if (cmd.clr_start) begin
         clr_cnt_in = '0;
      end else if (cmd.clr_step) begin
         clr_cnt_in = clr_cnt_ff + CLR_W'(1);
      end
      if (cmd.grow_commit) begin
         usable_in = usable_ff + CNT_W'(CHUNK);
      end
      if (cmd.scan_start) begin
         addr_in     = '0;
         rd_valid_in = 1'b0;
      end else if (cmd.scan_step) begin
         rd_valid_in = issue;
         if (issue) begin
            addr_in = addr_ff + CNT_W'(1);
         end
      end
      if (cmd.commit_add) begin
         used_in = used_ff + CNT_W'(1);
      end else if (cmd.commit_remove) begin
         used_in = used_dec;
         // table empties: usable capacity falls back to zero
         if (used_dec == '0) begin
            usable_in = '0;
         end
      end
      rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         usable_ff    <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         used_ff      <= used_in;
         usable_ff    <= usable_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff    <= addr_in;
      clr_cnt_ff <= clr_cnt_in;
      if (cmd.load_req) begin
         op_ff    <= op_type'(req_op);
         value_ff <= req_value;
         index_ff <= req_index;
      end
      if (cmd.scan_step) begin
         rd_addr_ff <= addr_ff[ADDR_W-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_index_ff  <= (cmd.rsp_status == ST_OK && op_ff != OP_GET) ? rd_addr_ff : '0;
         rsp_value_ff  <= (cmd.rsp_status == ST_OK && op_ff == OP_GET) ? rd_ff : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_index_ff;
   assign rsp_slot_value = rsp_value_ff;

   a_usable_bound: assert property (@(posedge clock) disable iff (reset)
      usable_ff <= CNT_W'(CAPACITY))
      else $error("usable capacity beyond store size");

   a_used_le_usable: assert property (@(posedge clock) disable iff (reset)
      used_ff <= usable_ff)
      else $error("used count above usable capacity");

   a_usable_chunks: assert property (@(posedge clock) disable iff (reset)
      (usable_ff % CNT_W'(CHUNK)) == '0)
      else $error("usable capacity not a whole number of chunks");

   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $countones({cmd.clr_step, cmd.commit_add, cmd.commit_remove}) <= 1)
      else $error("two writes to the slot store in one cycle");

endmodule

// ----- hw/rtl/stff_ctrl.sv -----
// stff_ctrl: sequencer of the slot table: decode, chunk clear, slot scan and
// result hand-off. Depends on stff_pkg.

module stff_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  stff_pkg::stat_type stat,
   output stff_pkg::cmd_type  cmd
);
   import stff_pkg::*;

   state_type  state_ff, state_in;
   status_type status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
   end

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      cmd            = '0;
      cmd.rsp_status = status_ff;
      req_stall      = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            state_in = S_FINISH;
            if (stat.op == OP_GET) begin
               if (stat.get_in_range) begin
                  cmd.get_read = 1'b1;
                  status_in    = ST_OK;
               end else begin
                  status_in = ST_INVALID;
               end
            end else if (stat.val_zero) begin
               status_in = ST_INVALID;
            end else if (stat.op == OP_ADD && stat.need_grow) begin
               if (stat.grow_fits) begin
                  cmd.clr_start = 1'b1;
                  state_in      = S_CLEAR;
               end else begin
                  status_in = ST_FULL;
               end
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = S_SCAN;
            end
         end
         S_CLEAR: begin
            // new chunk is zeroed one slot a cycle, then it joins the table
            cmd.clr_step = 1'b1;
            if (stat.clr_last) begin
               cmd.grow_commit = 1'b1;
               cmd.scan_start  = 1'b1;
               state_in        = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_hit) begin
               cmd.commit_add    = (stat.op == OP_ADD);
               cmd.commit_remove = (stat.op == OP_REMOVE);
               status_in         = ST_OK;
               state_in          = S_FINISH;
            end else if (stat.scan_end) begin
               status_in = (stat.op == OP_ADD) ? ST_FULL : ST_NOT_FOUND;
               state_in  = S_FINISH;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_scan_exclusive: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !(cmd.commit_add || cmd.commit_remove))
      else $error("scan advanced while a slot was committed");

   a_load_leaves: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |=> state_ff == S_IDLE)
      else $error("result loaded without returning to idle");

endmodule
